// ===== design/go_to_goal_pid_controller_assert.svh =====
// ----------------------------------------------------------------------------
// Go-to-goal PID controller assertion macros
// Property wrappers shared by the controller RTL.
// ----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_PID_CONTROLLER_ASSERT_SVH
`define GO_TO_GOAL_PID_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define GTG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GTG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gtg_pkg.sv =====
// ----------------------------------------------------------------------------
// Go-to-goal PID controller package
// Widths, constants, register indexes, state type and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package gtg_pkg;

    localparam int CORDIC_STEPS_DEF   = 24;
    localparam int INTEGRAL_WIDTH_DEF = 48;

    localparam int XW = 36;   // CORDIC x/y
    localparam int ZW = 37;   // angles, Q.30
    localparam int MW = 34;   // multiplier operand
    localparam int PRW = 2 * MW;
    localparam int SW = 66;   // command sums

    localparam logic signed [ZW-1:0] PI_Q30     = 37'sd3373259426;
    localparam logic signed [ZW-1:0] TWO_PI_Q30 = 37'sd6746518852;
    localparam logic signed [ZW-1:0] HEAD_LIMIT = 37'sd25736;
    localparam logic signed [ZW-1:0] HALF_LSB   = 37'sd65536;

    localparam logic [2:0] REG_VEL_KP = 3'd0;
    localparam logic [2:0] REG_VEL_KI = 3'd1;
    localparam logic [2:0] REG_VEL_KD = 3'd2;
    localparam logic [2:0] REG_ANG_KP = 3'd3;
    localparam logic [2:0] REG_ANG_KI = 3'd4;
    localparam logic [2:0] REG_ANG_KD = 3'd5;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // multiply sequence of the PID phase
    localparam logic [2:0] MOP_VKP = 3'd0;
    localparam logic [2:0] MOP_VKD = 3'd1;
    localparam logic [2:0] MOP_VLO = 3'd2;
    localparam logic [2:0] MOP_VHI = 3'd3;
    localparam logic [2:0] MOP_AKP = 3'd4;
    localparam logic [2:0] MOP_AKD = 3'd5;
    localparam logic [2:0] MOP_ALO = 3'd6;
    localparam logic [2:0] MOP_AHI = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_ITER,
        ST_ERR,
        ST_WRAP,
        ST_INTEG,
        ST_MUL,
        ST_FIN
    } t_state;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 37'sd843314857;
            5'd1:    v = 37'sd497837829;
            5'd2:    v = 37'sd263043837;
            5'd3:    v = 37'sd133525159;
            5'd4:    v = 37'sd67021687;
            5'd5:    v = 37'sd33543516;
            5'd6:    v = 37'sd16775851;
            5'd7:    v = 37'sd8388437;
            5'd8:    v = 37'sd4194283;
            5'd9:    v = 37'sd2097149;
            5'd10:   v = 37'sd1048576;
            5'd31:   v = '0;
            default: v = 37'sd1 <<< (5'd30 - i);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/gtg_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 34x34 multiply with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_mul (
    input  wire logic                            i_clk,
    input  wire logic signed [gtg_pkg::MW-1:0]   i_a,
    input  wire logic signed [gtg_pkg::MW-1:0]   i_b,
    output logic signed      [gtg_pkg::PRW-1:0]  o_prod
);

    logic signed [gtg_pkg::PRW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== design/go_to_goal_pid_controller.sv =====
// Sequence per update: square, 32-step root loop with CORDIC alongside, heading
//   wrap, PID multiplies, setup and finish; a clear goes straight to finish.
// One request is computed at a time on the root loop and the shared
//   34x34 multiplier. A new request is taken while a result waits.
// Reset (synchronous, active low) zeroes gains, integrals and previous errors.
// ----------------------------------------------------------------------------
// Go-to-goal PID controller
// Distance and bearing to a goal feed two saturating PID loops.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_pid_controller #(
    parameter int CORDIC_STEPS   = gtg_pkg::CORDIC_STEPS_DEF,
    parameter int INTEGRAL_WIDTH = gtg_pkg::INTEGRAL_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // robot_x, robot_y, robot_heading, goal_x, goal_y
    input  wire logic [143:0]  i_s_tdata,
    // operation
    input  wire logic          i_s_tuser,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    // velocity_cmd, turn_rate_cmd, range_to_goal, heading_error
    output logic [111:0]       o_m_tdata,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_addr,
    input  wire logic [15:0]   i_cfg_wdata
);

    `include "go_to_goal_pid_controller_assert.svh"

    localparam int W  = INTEGRAL_WIDTH;
    localparam int PW = (W + 18 > 64) ? W + 18 : 64;
    localparam int XW = gtg_pkg::XW;
    localparam int ZW = gtg_pkg::ZW;
    localparam int MW = gtg_pkg::MW;
    localparam int SW = gtg_pkg::SW;
    localparam logic signed [W:0]    IMAX = {2'b00, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] PLIM = PW'(64'sh4000000000000000);
    localparam logic signed [SW-1:0] S32MAX = SW'(64'sh000000007FFFFFFF);
    localparam logic signed [SW-1:0] S32MIN = -SW'(64'sh0000000080000000);

    gtg_pkg::t_state r_state, n_state;

    logic signed [15:0] r_gain [6];

    logic               r_clr;
    logic signed [15:0] r_head;
    logic [31:0]        r_ax, r_ay;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z, r_err;
    logic               r_zero;
    logic [63:0]        r_n, r_root;
    logic               r_ovf;
    logic [5:0]         r_k;
    logic [31:0]        r_dist, r_dprev;
    logic signed [15:0] r_e13, r_hprev;
    logic signed [W-1:0] r_di, r_hi;
    logic signed [PW-1:0] r_pacc_v, r_pacc_h;
    logic signed [SW-1:0] r_sacc_v, r_sacc_h;

    logic               r_mv;
    logic [31:0]        r_vel, r_turn, r_odist;
    logic [15:0]        r_ohead;

    logic signed [MW-1:0]  w_a, w_b;
    logic signed [2*MW-1:0] w_prod;

    logic w_acc, w_load;

    // ---------------------------------------------------------------- input
    logic signed [31:0] w_rx, w_ry, w_gx, w_gy;
    logic signed [32:0] w_dx, w_dy;
    assign w_rx = i_s_tdata[31:0];
    assign w_ry = i_s_tdata[63:32];
    assign w_gx = i_s_tdata[111:80];
    assign w_gy = i_s_tdata[143:112];
    assign w_dx = 33'(w_gx) - 33'(w_rx);
    assign w_dy = 33'(w_gy) - 33'(w_ry);

    // ---------------------------------------------------------------- FSM
    always_comb begin
        n_state = r_state;
        case (r_state)
            gtg_pkg::ST_IDLE:
                if (w_acc) n_state = (i_s_tuser == gtg_pkg::OP_CLEAR) ?
                                     gtg_pkg::ST_FIN : gtg_pkg::ST_SQ;
            gtg_pkg::ST_SQ:
                if (r_k == 6'd2) n_state = gtg_pkg::ST_ITER;
            gtg_pkg::ST_ITER:
                if (r_k == 6'd31) n_state = gtg_pkg::ST_ERR;
            gtg_pkg::ST_ERR:
                n_state = gtg_pkg::ST_WRAP;
            gtg_pkg::ST_WRAP:
                if (r_err <= gtg_pkg::PI_Q30 && r_err >= -gtg_pkg::PI_Q30)
                    n_state = gtg_pkg::ST_INTEG;
            gtg_pkg::ST_INTEG:
                n_state = gtg_pkg::ST_MUL;
            gtg_pkg::ST_MUL:
                if (r_k == 6'd8) n_state = gtg_pkg::ST_FIN;
            gtg_pkg::ST_FIN:
                if (!r_mv || i_m_tready) n_state = gtg_pkg::ST_IDLE;
            default:
                n_state = gtg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = (r_state == gtg_pkg::ST_IDLE);
        w_load     = (r_state == gtg_pkg::ST_FIN) && (!r_mv || i_m_tready);
    end

    assign w_acc = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= gtg_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // ---------------------------------------------------------------- multiplier
    always_comb begin
        w_a = MW'({2'b00, r_ax});
        w_b = MW'({2'b00, r_ax});
        if (r_state == gtg_pkg::ST_SQ) begin
            if (r_k == 6'd1) begin
                w_a = MW'({2'b00, r_ay});
                w_b = MW'({2'b00, r_ay});
            end
        end else begin
            case (r_k[2:0])
                gtg_pkg::MOP_VKP: begin
                    w_a = MW'(r_gain[gtg_pkg::REG_VEL_KP]);
                    w_b = MW'({2'b00, r_dist});
                end
                gtg_pkg::MOP_VKD: begin
                    w_a = MW'(r_gain[gtg_pkg::REG_VEL_KD]);
                    w_b = MW'($signed({1'b0, r_dist}) - $signed({1'b0, r_dprev}));
                end
                gtg_pkg::MOP_VLO: begin
                    w_a = MW'(r_gain[gtg_pkg::REG_VEL_KI]);
                    w_b = MW'({2'b00, r_di[31:0]});
                end
                gtg_pkg::MOP_VHI: begin
                    w_a = MW'(r_gain[gtg_pkg::REG_VEL_KI]);
                    w_b = MW'(r_di >>> 32);
                end
                gtg_pkg::MOP_AKP: begin
                    w_a = MW'(r_gain[gtg_pkg::REG_ANG_KP]);
                    w_b = MW'(r_e13);
                end
                gtg_pkg::MOP_AKD: begin
                    w_a = MW'(r_gain[gtg_pkg::REG_ANG_KD]);
                    w_b = MW'(17'(r_e13) - 17'(r_hprev));
                end
                gtg_pkg::MOP_ALO: begin
                    w_a = MW'(r_gain[gtg_pkg::REG_ANG_KI]);
                    w_b = MW'({2'b00, r_hi[31:0]});
                end
                gtg_pkg::MOP_AHI: begin
                    w_a = MW'(r_gain[gtg_pkg::REG_ANG_KI]);
                    w_b = MW'(r_hi >>> 32);
                end
                default: ;
            endcase
        end
    end

    gtg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    // ---------------------------------------------------------------- root / CORDIC step
    logic [63:0]          w_bit;
    logic [64:0]          w_trial;
    logic signed [XW-1:0] w_xs, w_ys;
    logic signed [ZW-1:0] w_at;
    logic                 w_cord_en;
    assign w_bit     = 64'h4000000000000000 >> {r_k[4:0], 1'b0};
    assign w_trial   = {1'b0, r_root} + {1'b0, w_bit};
    assign w_xs      = r_x >>> r_k[4:0];
    assign w_ys      = r_y >>> r_k[4:0];
    assign w_at      = gtg_pkg::atan_q30(r_k[4:0]);
    assign w_cord_en = !r_zero && (r_k < 6'(CORDIC_STEPS));

    // ---------------------------------------------------------------- wrap, integrals, finish
    logic signed [ZW-1:0] w_er, w_ec;
    assign w_er = (r_err + gtg_pkg::HALF_LSB) >>> 17;
    assign w_ec = (w_er > gtg_pkg::HEAD_LIMIT)  ? gtg_pkg::HEAD_LIMIT :
                  (w_er < -gtg_pkg::HEAD_LIMIT) ? -gtg_pkg::HEAD_LIMIT : w_er;

    logic signed [W:0] w_dsum, w_hsum, w_dsat, w_hsat;
    assign w_dsum = {r_di[W-1], r_di} + $signed({{(W-31){1'b0}}, r_dist});
    assign w_hsum = {r_hi[W-1], r_hi} + (W+1)'(r_e13);
    assign w_dsat = (w_dsum > IMAX) ? IMAX : (w_dsum < -IMAX) ? -IMAX : w_dsum;
    assign w_hsat = (w_hsum > IMAX) ? IMAX : (w_hsum < -IMAX) ? -IMAX : w_hsum;

    logic signed [PW-1:0] w_pext;
    logic [2:0]           w_aidx;
    assign w_pext = PW'(w_prod);
    assign w_aidx = 3'(r_k - 6'd1);

    logic signed [PW-1:0] w_pvc, w_phc;
    logic signed [SW-1:0] w_tv, w_th, w_vs, w_hs;
    logic [31:0]          w_vel, w_turn;
    assign w_pvc = (r_pacc_v > PLIM) ? PLIM : (r_pacc_v < -PLIM) ? -PLIM : r_pacc_v;
    assign w_phc = (r_pacc_h > PLIM) ? PLIM : (r_pacc_h < -PLIM) ? -PLIM : r_pacc_h;
    assign w_tv  = r_sacc_v + SW'(w_pvc);
    assign w_th  = r_sacc_h + SW'(w_phc);
    assign w_vs  = w_tv >>> 8;
    assign w_hs  = w_th >>> 5;
    assign w_vel  = (w_vs > S32MAX) ? 32'h7FFFFFFF : (w_vs < S32MIN) ? 32'h80000000 :
                    w_vs[31:0];
    assign w_turn = (w_hs > S32MAX) ? 32'h7FFFFFFF : (w_hs < S32MIN) ? 32'h80000000 :
                    w_hs[31:0];

    // ---------------------------------------------------------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < 6; g++) r_gain[g] <= '0;
            r_di    <= '0;
            r_hi    <= '0;
            r_dprev <= '0;
            r_hprev <= '0;
            r_mv    <= 1'b0;
            r_k     <= '0;
        end else begin
            if (i_cfg_we && i_cfg_addr <= gtg_pkg::REG_ANG_KD)
                r_gain[i_cfg_addr] <= i_cfg_wdata;

            if (w_acc && i_s_tuser == gtg_pkg::OP_CLEAR) begin
                r_di    <= '0;
                r_hi    <= '0;
                r_dprev <= '0;
                r_hprev <= '0;
            end
            if (r_state == gtg_pkg::ST_INTEG) begin
                r_di <= W'(w_dsat);
                r_hi <= W'(w_hsat);
            end
            if (w_load && !r_clr) begin
                r_dprev <= r_dist;
                r_hprev <= r_e13;
            end

            if (w_load)          r_mv <= 1'b1;
            else if (i_m_tready) r_mv <= 1'b0;

            if (r_state == gtg_pkg::ST_SQ || r_state == gtg_pkg::ST_ITER ||
                r_state == gtg_pkg::ST_MUL) begin
                r_k <= (n_state != r_state) ? 6'd0 : r_k + 6'd1;
            end else begin
                r_k <= '0;
            end
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_clr  <= (i_s_tuser == gtg_pkg::OP_CLEAR);
            r_head <= i_s_tdata[79:64];
            r_ax   <= w_dx[32] ? 32'(-w_dx) : w_dx[31:0];
            r_ay   <= w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
            r_zero <= (w_dx == '0) && (w_dy == '0);
            r_root <= '0;
            if (w_dx[32]) begin
                r_x <= -XW'(w_dx);
                r_y <= -XW'(w_dy);
                r_z <= w_dy[32] ? -gtg_pkg::PI_Q30 : gtg_pkg::PI_Q30;
            end else begin
                r_x <= XW'(w_dx);
                r_y <= XW'(w_dy);
                r_z <= '0;
            end
        end

        case (r_state)
            gtg_pkg::ST_SQ: begin
                if (r_k == 6'd1) {r_ovf, r_n} <= {1'b0, w_prod[63:0]};
                if (r_k == 6'd2) {r_ovf, r_n} <= {1'b0, r_n} + {1'b0, w_prod[63:0]};
            end
            gtg_pkg::ST_ITER: begin
                if ({1'b0, r_n} >= w_trial) begin
                    r_n    <= r_n - w_trial[63:0];
                    r_root <= (r_root >> 1) + w_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                if (w_cord_en) begin
                    if (r_y < 0) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_at;
                    end
                end
            end
            gtg_pkg::ST_ERR: begin
                r_err  <= r_z - (ZW'(r_head) <<< 17);
                r_dist <= r_ovf ? 32'hFFFFFFFF : r_root[31:0];
            end
            gtg_pkg::ST_WRAP: begin
                if (r_err > gtg_pkg::PI_Q30)       r_err <= r_err - gtg_pkg::TWO_PI_Q30;
                else if (r_err < -gtg_pkg::PI_Q30) r_err <= r_err + gtg_pkg::TWO_PI_Q30;
                r_e13 <= 16'(w_ec);
            end
            gtg_pkg::ST_INTEG: begin
                r_pacc_v <= '0;
                r_pacc_h <= '0;
                r_sacc_v <= '0;
                r_sacc_h <= '0;
            end
            gtg_pkg::ST_MUL: begin
                if (r_k != 6'd0) begin
                    case (w_aidx)
                        gtg_pkg::MOP_VKP, gtg_pkg::MOP_VKD:
                            r_sacc_v <= r_sacc_v + SW'(w_prod);
                        gtg_pkg::MOP_VLO: r_pacc_v <= r_pacc_v + w_pext;
                        gtg_pkg::MOP_VHI: r_pacc_v <= r_pacc_v + (w_pext <<< 32);
                        gtg_pkg::MOP_AKP, gtg_pkg::MOP_AKD:
                            r_sacc_h <= r_sacc_h + SW'(w_prod);
                        gtg_pkg::MOP_ALO: r_pacc_h <= r_pacc_h + w_pext;
                        gtg_pkg::MOP_AHI: r_pacc_h <= r_pacc_h + (w_pext <<< 32);
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        if (w_load) begin
            r_vel   <= r_clr ? '0 : w_vel;
            r_turn  <= r_clr ? '0 : w_turn;
            r_odist <= r_clr ? '0 : r_dist;
            r_ohead <= r_clr ? '0 : r_e13;
        end
    end

    assign o_m_tvalid = r_mv;
    assign o_m_tdata  = {r_ohead, r_odist, r_turn, r_vel};

    // ---------------------------------------------------------------- checks
    `GTG_ASSERT_NXT(a_clear_zeroes, i_clk, i_rst_n,
        w_acc && i_s_tuser == gtg_pkg::OP_CLEAR,
        r_di == '0 && r_hi == '0 && r_dprev == '0 && r_hprev == '0,
        "clear request did not zero loop state")
    `GTG_ASSERT_NXT(a_load_valid, i_clk, i_rst_n, w_load, o_m_tvalid,
        "finished result not presented")
    `GTG_ASSERT_IMP(a_head_range, i_clk, i_rst_n, o_m_tvalid,
        $signed(o_m_tdata[111:96]) <= 16'sd25736 &&
        $signed(o_m_tdata[111:96]) >= -16'sd25736,
        "heading error out of range")
    `GTG_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n,
        r_state == gtg_pkg::ST_MUL || r_state == gtg_pkg::ST_ITER, !o_s_tready,
        "request taken during computation")

endmodule

`default_nettype wire

// ===== verif/go_to_goal_pid_controller_test.sv =====
// ----------------------------------------------------------------------------
// Go-to-goal PID controller testbench
// Directed rows and random update/clear requests across several gain settings.
// Each accepted request is scored by a local model of the distance/bearing
// math and both PID loops; results are checked in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_pid_controller_test;

    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam int N_RAND_PHASES = 4;
    localparam int N_RAND_ITEMS = 200;
    localparam int QUIET_ITEMS = 100;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam longint IMAX = (64'sd1 <<< (gtg_pkg::INTEGRAL_WIDTH_DEF - 1)) - 1;
    localparam longint PLIM = 64'sd1 <<< 62;

    typedef struct packed {
        logic        op;
        logic [31:0] rx;
        logic [31:0] ry;
        logic [15:0] hd;
        logic [31:0] gx;
        logic [31:0] gy;
        logic        typed;   // expected result below holds (zero-gain phase only)
        logic [31:0] e_vel;
        logic [31:0] e_turn;
        logic [31:0] e_dist;
        logic [15:0] e_head;
    } req_t;

    typedef struct packed {
        logic [31:0] vel;
        logic [31:0] turn;
        logic [31:0] gdist;
        logic [15:0] head;
    } cmd_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [143:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] m_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [15:0]  cfg_wdata = '0;

    // typed expectation travels alongside the request
    logic         req_typed = 1'b0;
    cmd_t         req_typed_cmd = '0;

    go_to_goal_pid_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // model state
    logic signed [15:0] gains [6];
    longint dist_integ, head_integ, dist_prev, head_prev;
    cmd_t   cmd_q [$];
    int     n_errors = 0;
    int     idle_cnt = 0;
    bit     quiet = 0;
    int     hold_kick = 0;

    function automatic longint atan_q30_step(int i);
        longint tab [11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                             33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
        if (i < 11) return tab[i];
        if (i <= 30) return 64'sd1 <<< (30 - i);
        return 0;
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint integ_add(longint acc, longint s);
        acc = acc + s;
        if (acc > IMAX) acc = IMAX;
        if (acc < -IMAX) acc = -IMAX;
        return acc;
    endfunction

    function automatic longint clamp_prod(longint g, longint v);
        longint p;
        p = g * v;
        if (p > PLIM) p = PLIM;
        if (p < -PLIM) p = -PLIM;
        return p;
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic cmd_t pid_step(logic op, logic [143:0] d);
        cmd_t   c;
        longint dx, dy, x, y, z, xs, ys, err, e13, span, sum;
        logic [63:0] ax, ay, sqx, sqy;
        logic [64:0] sq;
        c = '0;
        if (op == gtg_pkg::OP_CLEAR) begin
            dist_integ = 0; dist_prev = 0; head_integ = 0; head_prev = 0;
            return c;
        end
        dx = longint'($signed(d[111:80])) - longint'($signed(d[31:0]));
        dy = longint'($signed(d[143:112])) - longint'($signed(d[63:32]));
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        sqx = ax * ax;
        sqy = ay * ay;
        sq = {1'b0, sqx} + {1'b0, sqy};
        span = sq[64] ? 64'hFFFFFFFF : longint'(isqrt(sq[63:0]));
        z = 0;
        if (dx != 0 || dy != 0) begin
            x = dx;
            y = dy;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = (dy >= 0) ? longint'(gtg_pkg::PI_Q30) : -longint'(gtg_pkg::PI_Q30);
            end
            for (int i = 0; i < gtg_pkg::CORDIC_STEPS_DEF; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y < 0) begin
                    x -= ys; y += xs; z -= atan_q30_step(i);
                end else begin
                    x += ys; y -= xs; z += atan_q30_step(i);
                end
            end
        end
        err = z - longint'($signed(d[79:64])) * 131072;
        while (err > longint'(gtg_pkg::PI_Q30)) err -= longint'(gtg_pkg::TWO_PI_Q30);
        while (err < -longint'(gtg_pkg::PI_Q30)) err += longint'(gtg_pkg::TWO_PI_Q30);
        e13 = (err + 65536) >>> 17;
        if (e13 > 25736) e13 = 25736;
        if (e13 < -25736) e13 = -25736;

        dist_integ = integ_add(dist_integ, span);
        sum = longint'(gains[gtg_pkg::REG_VEL_KP]) * span
            + clamp_prod(gains[gtg_pkg::REG_VEL_KI], dist_integ)
            + longint'(gains[gtg_pkg::REG_VEL_KD]) * (span - dist_prev);
        c.vel = sat32(sum >>> 8);
        dist_prev = span;

        head_integ = integ_add(head_integ, e13);
        sum = longint'(gains[gtg_pkg::REG_ANG_KP]) * e13
            + clamp_prod(gains[gtg_pkg::REG_ANG_KI], head_integ)
            + longint'(gains[gtg_pkg::REG_ANG_KD]) * (e13 - head_prev);
        c.turn = sat32(sum >>> 5);
        head_prev = e13;

        c.gdist = span[31:0];
        c.head = e13[15:0];
        return c;
    endfunction

    // request and config capture
    always @(posedge i_clk) begin
        cmd_t c;
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) gains[k] = '0;
            dist_integ = 0; dist_prev = 0; head_integ = 0; head_prev = 0;
        end else begin
            if (cfg_we && cfg_addr <= gtg_pkg::REG_ANG_KD) gains[cfg_addr] = cfg_wdata;
            if (s_tvalid && s_tready) begin
                c = pid_step(s_tuser, s_tdata);
                cmd_q.push_back(req_typed ? req_typed_cmd : c);
            end
        end
    end

    // result checking
    always @(posedge i_clk) begin
        cmd_t got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.vel   = m_tdata[31:0];
            got.turn  = m_tdata[63:32];
            got.gdist = m_tdata[95:64];
            got.head  = m_tdata[111:96];
            if (cmd_q.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                n_errors++;
            end else begin
                want = cmd_q.pop_front();
                if (got.vel !== want.vel) begin
                    $error("velocity_cmd exp %h got %h", want.vel, got.vel); n_errors++;
                end
                if (got.turn !== want.turn) begin
                    $error("turn_rate_cmd exp %h got %h", want.turn, got.turn); n_errors++;
                end
                if (got.gdist !== want.gdist) begin
                    $error("range_to_goal exp %h got %h", want.gdist, got.gdist);
                    n_errors++;
                end
                if (got.head !== want.head) begin
                    $error("heading_error exp %h got %h", want.head, got.head); n_errors++;
                end
            end
        end
    end

    // receiver: random stalls, one long hold on request
    always @(posedge i_clk) begin
        static int stall = 0;
        static int hold = 0;
        static int kick_seen = 0;
        if (hold_kick != kick_seen) begin
            kick_seen = hold_kick;
            hold = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold > 0) begin
            hold--;
            m_tready <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall > 0) begin
            stall--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall = $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !i_rst_n)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("go_to_goal_pid_controller_test: errors");
            $finish;
        end
    end

    task automatic send(req_t r);
        s_tvalid <= 1'b1;
        s_tuser <= r.op;
        s_tdata <= {r.gy, r.gx, r.hd, r.ry, r.rx};
        req_typed <= r.typed && (gains[gtg_pkg::REG_VEL_KP] == 0);
        req_typed_cmd <= {r.e_vel, r.e_turn, r.e_dist, r.e_head};
        do @(posedge i_clk); while (!s_tready);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // idle only: queue drained before any write
    task automatic set_gains(logic [15:0] g [6]);
        for (int k = 0; k < 6; k++) begin
            @(posedge i_clk);
            cfg_we <= 1'b1;
            cfg_addr <= k[2:0];
            cfg_wdata <= g[k];
        end
        @(posedge i_clk);
        cfg_addr <= 3'(REG_UNUSED + $urandom_range(0, 1));
        cfg_wdata <= 16'($urandom);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic req_t rand_req();
        req_t r;
        r = '0;
        r.op = ($urandom_range(0, 19) == 0) ? gtg_pkg::OP_CLEAR : gtg_pkg::OP_UPDATE;
        r.rx = $urandom;
        r.ry = $urandom;
        if ($urandom_range(0, 9) < 7) begin
            r.gx = r.rx + $signed($urandom_range(0, 2 ** 21) - 2 ** 20);
            r.gy = r.ry + $signed($urandom_range(0, 2 ** 21) - 2 ** 20);
        end else begin
            r.gx = $urandom;
            r.gy = $urandom;
        end
        if ($urandom_range(0, 99) < 85)
            r.hd = 16'($urandom_range(0, 51472) - 25736);
        else
            r.hd = 16'($urandom);
        return r;
    endfunction

    function automatic req_t row(logic op, logic [31:0] rx, ry, logic [15:0] hd,
                                 logic [31:0] gx, gy, logic typed);
        req_t r;
        r = '0;
        r.op = op; r.rx = rx; r.ry = ry; r.hd = hd; r.gx = gx; r.gy = gy;
        r.typed = typed;   // typed rows expect an all-zero result
        return r;
    endfunction

    req_t dir_tab [$];
    logic [15:0] g [6];

    initial begin
        dir_tab = '{
            row(gtg_pkg::OP_CLEAR, 32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 32'hFFFFFFFF,
                32'h1, 1'b1),
            row(gtg_pkg::OP_UPDATE, 32'h0, 32'h0, 16'h0, 32'h0, 32'h0, 1'b1), // goal at robot
            row(gtg_pkg::OP_UPDATE, 32'h12345, 32'hFFFF0000, 16'h0, 32'h12345,
                32'hFFFF0000, 1'b1),
            row(gtg_pkg::OP_UPDATE, 32'h80000000, 32'h80000000, 16'd25736,
                32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0),                      // distance overflow
            row(gtg_pkg::OP_UPDATE, 32'h7FFFFFFF, 32'h0, -16'sd25736, 32'h80000000,
                32'h0, 1'b0),
            row(gtg_pkg::OP_UPDATE, 32'h0, 32'h80000000, 16'h7FFF, 32'h0, 32'h7FFFFFFF,
                1'b0),
            row(gtg_pkg::OP_UPDATE, 32'h0, 32'h0, 16'h8000, 32'hFFFF0000, 32'h1,
                1'b0),                                                  // heading off range
            row(gtg_pkg::OP_UPDATE, 32'h0, 32'h0, 16'h0, 32'hFFFF0000, 32'hFFFFFFFF, 1'b0),
            row(gtg_pkg::OP_UPDATE, 32'h0, 32'h0, 16'h0, 32'h10000, 32'h0, 1'b0),
            row(gtg_pkg::OP_UPDATE, 32'h0, 32'h0, 16'h1000, 32'h0, 32'h10000, 1'b0),
            row(gtg_pkg::OP_UPDATE, 32'h0, 32'h0, 16'hF000, 32'hFFFF0000, 32'h0, 1'b0),
            row(gtg_pkg::OP_UPDATE, 32'h55555555, 32'hAAAAAAAA, 16'h5555, 32'hAAAAAAAA,
                32'h55555555, 1'b0),
            row(gtg_pkg::OP_CLEAR, 32'h0, 32'h0, 16'h0, 32'h0, 32'h0, 1'b1),
            row(gtg_pkg::OP_UPDATE, 32'h0, 32'h0, 16'h6488, 32'h7FFFFFFF, 32'h7FFFFFFF,
                1'b0)
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero, max and min gains over the directed rows
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 6; k++) g[k] = (p == 0) ? 16'h0 : (p == 1) ? 16'h7FFF : 16'h8000;
            drain();
            set_gains(g);
            foreach (dir_tab[i]) send(dir_tab[i]);
        end

        for (int p = 0; p < N_RAND_PHASES; p++) begin
            for (int k = 0; k < 6; k++)
                g[k] = ($urandom_range(0, 1) == 0) ? 16'($urandom) :
                       16'($urandom_range(0, 1023) - 512);
            drain();
            set_gains(g);
            for (int i = 0; i < N_RAND_ITEMS; i++) begin
                if (p == 0 && i == 20) hold_kick++;
                if (p == 1 && i == 50) begin
                    s_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (cmd_q.size() != 0) @(posedge i_clk);
                end
                if (p == N_RAND_PHASES - 1 && i == N_RAND_ITEMS - QUIET_ITEMS) quiet = 1;
                send(rand_req());
            end
        end
        drain();

        if (n_errors == 0)
            $display("go_to_goal_pid_controller_test: clean");
        else
            $display("go_to_goal_pid_controller_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
